@@ hdl/crse_pkg.sv @@
// Package of shared widths, command codes and sequencer states of the Catmull-Rom evaluator.
package crse_pkg;

    // Coordinate and curve parameter formats
    localparam int CW  = 24;            // coordinate width, signed Q15.8
    localparam int TF  = 16;            // fraction bits of t
    localparam int TW  = TF + 1;        // width of t, unsigned Q1.16
    localparam int AW  = CW + 4;        // coefficient width, one extra fraction bit
    localparam int ACW = AW + 2;        // Horner accumulator width
    localparam int PW  = ACW + TW + 1;  // product width of the shared multiplier

    // Input and output payload layout
    localparam int S_TDATA_W = ((2 * CW + TW + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * CW + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;

    localparam logic [TW-1:0] T_ONE = TW'(1) << TF;

    localparam logic signed [ACW-1:0] COORD_MAX = ACW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [ACW-1:0] COORD_MIN = -COORD_MAX - ACW'(1);

    // Command codes carried in tuser
    localparam logic [S_TUSER_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [S_TUSER_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [S_TUSER_W-1:0] CMD_EVAL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF_A,
        ST_COEF_B,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [AW-1:0] t_coef;

endpackage

@@ hdl/catmull_rom_segment_evaluator_core.sv @@
// Catmull-Rom segment evaluator: point window, coefficient update and shared-multiplier Horner.
// A user of this block sends one beat per command. Clear keeps the coefficients. Add point
// moves the window in the accept cycle and then rebuilds the x and y cubic coefficients of
// the middle segment in the ST_COEF_A and ST_COEF_B states. Evaluate runs both axes through
// three Horner steps on a single 30 x 18 bit multiplier, each step being a multiply state
// and a round-and-add state, followed by a rounding and saturation state per axis and a
// state that loads the output register once it is free. The input side is ready only while
// the sequencer is idle; a finished result waits in the output register while the next
// command is accepted.
module catmull_rom_segment_evaluator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // point_x [23:0], point_y [47:24], t_fraction [64:48], zero pad above
    input  logic [crse_pkg::S_TDATA_W-1:0] i_s_tdata,
    // command [1:0]
    input  logic [crse_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // curve_x [23:0], curve_y [47:24]
    output logic [crse_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import crse_pkg::*;

    t_state r_state, n_state;

    t_coord r_win_x [4];
    t_coord r_win_y [4];
    t_coef  r_coef_x [4];
    t_coef  r_coef_y [4];
    logic [2:0] r_points_held;

    logic [TW-1:0]          r_t;
    logic [1:0]             r_k;
    logic                   r_axis;
    logic signed [ACW-1:0]  r_acc;
    logic signed [PW-1:0]   r_prod;
    t_coord                 r_res_x;
    t_coord                 r_res_y;
    logic                   r_m_tvalid;
    logic [M_TDATA_W-1:0]   r_m_tdata;

    logic       s_accept;
    logic       out_free;
    t_coord     in_x, in_y;
    logic [TW-1:0] in_t;
    logic signed [PW-1:0]  prod_round;
    logic signed [ACW-1:0] acc_mul;
    t_coef                 coef_k;
    logic signed [ACW-1:0] acc_half;
    t_coord                sat_res;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign in_x = t_coord'(i_s_tdata[CW-1:0]);
    assign in_y = t_coord'(i_s_tdata[2*CW-1:CW]);
    assign in_t = i_s_tdata[2*CW+TW-1:2*CW];

    // Round the product half up to the accumulator scale and add the next coefficient
    always_comb begin
        coef_k = r_axis ? r_coef_y[r_k] : r_coef_x[r_k];
        prod_round = r_prod + PW'(1 <<< (TF - 1));
        acc_mul = signed'(prod_round[ACW+TF-1:TF]) + ACW'(coef_k);
    end

    // Drop the extra fraction bit with rounding and clamp to the coordinate range
    always_comb begin
        acc_half = (r_acc + ACW'(1)) >>> 1;
        if (acc_half > COORD_MAX) begin
            sat_res = t_coord'(COORD_MAX);
        end else if (acc_half < COORD_MIN) begin
            sat_res = t_coord'(COORD_MIN);
        end else begin
            sat_res = t_coord'(acc_half);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == CMD_ADD) begin
                        n_state = ST_COEF_A;
                    end else if (i_s_tuser == CMD_EVAL) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_COEF_A: n_state = ST_COEF_B;
            ST_COEF_B: n_state = ST_IDLE;
            ST_MUL:    n_state = ST_ACC;
            ST_ACC:    n_state = (r_k == 2'd0) ? ST_FIN : ST_MUL;
            ST_FIN:    n_state = r_axis ? ST_OUT : ST_MUL;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Port outputs
    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        o_m_tvalid = r_m_tvalid;
        o_m_tdata  = r_m_tdata;
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_points_held <= 3'd0;
            r_m_tvalid    <= 1'b0;
            r_axis        <= 1'b0;
            r_k           <= 2'd0;
            for (int i = 0; i < 4; i++) begin
                r_win_x[i]  <= '0;
                r_win_y[i]  <= '0;
                r_coef_x[i] <= '0;
                r_coef_y[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // Load the output register once it is free, drop the beat once taken
            if (r_state == ST_OUT && out_free) begin
                r_m_tvalid <= 1'b1;
                r_m_tdata  <= M_TDATA_W'({r_res_y, r_res_x});
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept && i_s_tuser == CMD_CLEAR) begin
                        r_points_held <= 3'd0;
                    end
                    // Slide the window, or repeat the new point into the free slots
                    if (s_accept && i_s_tuser == CMD_ADD) begin
                        if (r_points_held >= 3'd4) begin
                            for (int i = 0; i < 3; i++) begin
                                r_win_x[i] <= r_win_x[i+1];
                                r_win_y[i] <= r_win_y[i+1];
                            end
                            r_win_x[3] <= in_x;
                            r_win_y[3] <= in_y;
                        end else begin
                            for (int i = 0; i < 4; i++) begin
                                if (3'(i) >= r_points_held) begin
                                    r_win_x[i] <= in_x;
                                    r_win_y[i] <= in_y;
                                end
                            end
                            r_points_held <= r_points_held + 3'd1;
                        end
                    end
                    // Load the top coefficient and the clamped t for Horner
                    if (s_accept && i_s_tuser == CMD_EVAL) begin
                        r_t    <= (in_t > T_ONE) ? T_ONE : in_t;
                        r_acc  <= ACW'(r_coef_x[3]);
                        r_k    <= 2'd2;
                        r_axis <= 1'b0;
                    end
                end
                ST_COEF_A: begin
                    // a0 = 2*w1, a1 = near tangent, a3 = 4*(w1-w2) + near + far
                    r_coef_x[0] <= AW'(r_win_x[1]) <<< 1;
                    r_coef_y[0] <= AW'(r_win_y[1]) <<< 1;
                    r_coef_x[1] <= AW'(r_win_x[2]) - AW'(r_win_x[0]);
                    r_coef_y[1] <= AW'(r_win_y[2]) - AW'(r_win_y[0]);
                    r_coef_x[3] <= ((AW'(r_win_x[1]) - AW'(r_win_x[2])) <<< 2)
                                 + (AW'(r_win_x[2]) - AW'(r_win_x[0]))
                                 + (AW'(r_win_x[3]) - AW'(r_win_x[1]));
                    r_coef_y[3] <= ((AW'(r_win_y[1]) - AW'(r_win_y[2])) <<< 2)
                                 + (AW'(r_win_y[2]) - AW'(r_win_y[0]))
                                 + (AW'(r_win_y[3]) - AW'(r_win_y[1]));
                end
                ST_COEF_B: begin
                    // a2 = 2*w2 - a0 - a1 - a3
                    r_coef_x[2] <= (AW'(r_win_x[2]) <<< 1) - r_coef_x[0]
                                 - r_coef_x[1] - r_coef_x[3];
                    r_coef_y[2] <= (AW'(r_win_y[2]) <<< 1) - r_coef_y[0]
                                 - r_coef_y[1] - r_coef_y[3];
                end
                ST_MUL: begin
                    r_prod <= PW'(r_acc) * PW'(signed'({1'b0, r_t}));
                end
                ST_ACC: begin
                    r_acc <= acc_mul;
                    r_k   <= r_k - 2'd1;
                end
                ST_FIN: begin
                    // Hold x and restart Horner on the y coefficients
                    if (!r_axis) begin
                        r_res_x <= sat_res;
                        r_acc   <= ACW'(r_coef_y[3]);
                        r_k     <= 2'd2;
                        r_axis  <= 1'b1;
                    end else begin
                        r_res_y <= sat_res;
                    end
                end
                ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Window fill count never passes four
    a_points_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_points_held <= 3'd4)
        else $error("points held out of range");

    // Every accumulate step follows a multiply step
    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACC |-> $past(r_state) == ST_MUL)
        else $error("accumulate without multiply");

    // An accepted evaluate starts the multiplier on the x axis
    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == CMD_EVAL) |=> (r_state == ST_MUL && !r_axis && r_k == 2'd2))
        else $error("evaluate did not start Horner");

    // An accepted clear empties the window
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == CMD_CLEAR) |=> r_points_held == 3'd0)
        else $error("clear did not empty the window");

    // The output register only loads when it is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !out_free) |=> r_state == ST_OUT)
        else $error("result dropped while output full");

endmodule

@@ tb/catmull_rom_segment_evaluator_core_tb.sv @@
// Self-checking testbench of the Catmull-Rom segment evaluator core with its own curve predictor.
module catmull_rom_segment_evaluator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crse_pkg::*;

    // Command code that the block leaves unused
    localparam logic [S_TUSER_W-1:0] CMD_SPARE = 2'd3;

    localparam t_coord CURVE_TOP    = 24'sh7FFFFF;
    localparam t_coord CURVE_BOTTOM = 24'sh800000;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 48;

    typedef struct packed {
        t_coord cx;
        t_coord cy;
    } t_curve_pt;

    // One row of the directed plan; typed rows carry a result fixed by hand
    typedef struct packed {
        logic [S_TUSER_W-1:0] cmd;
        t_coord               px;
        t_coord               py;
        logic [TW-1:0]        tf;
        bit                   typed;
        t_curve_pt            fixed;
    } t_plan_row;

    localparam int PLAN_LEN = 27;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predictor state: window and coefficients per axis (0 = x, 1 = y)
    longint      win [2][4];
    longint      coef [2][4];
    int unsigned held;

    t_curve_pt   curve_due [$];
    t_curve_pt   due_pt;
    int          gap_pct;
    int          stall_pct;
    int          errors;
    int          cycle_count;
    int          n_add, n_eval, n_clear, n_spare, n_clamp, n_results;

    catmull_rom_segment_evaluator_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Rebuild the Hermite coefficients of the middle segment for one axis
    function automatic void rebuild_coefs(int ax);
        coef[ax][0] = 2 * win[ax][1];
        coef[ax][1] = win[ax][2] - win[ax][0];
        coef[ax][3] = 4 * (win[ax][1] - win[ax][2]) + (win[ax][2] - win[ax][0])
                    + (win[ax][3] - win[ax][1]);
        coef[ax][2] = 2 * win[ax][2] - coef[ax][0] - coef[ax][1] - coef[ax][3];
    endfunction

    // Slide a coordinate into the window, repeating it into empty slots
    function automatic void slide_in(int ax, longint v);
        int i;
        if (held >= 4) begin
            win[ax][0] = win[ax][1];
            win[ax][1] = win[ax][2];
            win[ax][2] = win[ax][3];
            win[ax][3] = v;
        end else begin
            for (i = held; i < 4; i++)
                win[ax][i] = v;
        end
    endfunction

    // Horner evaluation with half-up rounding, then narrow and clamp
    function automatic t_coord curve_at(int ax, longint tv);
        longint acc;
        longint top;
        longint bottom;
        int     k;
        top    = (longint'(1) <<< (CW - 1)) - 1;
        bottom = -top - 1;
        acc    = coef[ax][3];
        for (k = 2; k >= 0; k--)
            acc = ((acc * tv + (longint'(1) <<< (TF - 1))) >>> TF) + coef[ax][k];
        acc = (acc + 1) >>> 1;
        if (acc > top) begin
            acc = top;
            n_clamp++;
        end else if (acc < bottom) begin
            acc = bottom;
            n_clamp++;
        end
        return t_coord'(acc);
    endfunction

    // Advance the predictor by one beat; return 1 when a curve point is due
    function automatic bit predict_curve(logic [S_TUSER_W-1:0] cmd, t_coord px, t_coord py,
                                         logic [TW-1:0] tf, output t_curve_pt pt);
        longint tv;
        pt = '0;
        case (cmd)
            CMD_CLEAR: begin
                held = 0;
                n_clear++;
                return 1'b0;
            end
            CMD_ADD: begin
                slide_in(0, longint'(px));
                slide_in(1, longint'(py));
                if (held < 4)
                    held++;
                rebuild_coefs(0);
                rebuild_coefs(1);
                n_add++;
                return 1'b0;
            end
            CMD_EVAL: begin
                tv = (tf > T_ONE) ? longint'(T_ONE) : longint'(tf);
                pt.cx = curve_at(0, tv);
                pt.cy = curve_at(1, tv);
                n_eval++;
                return 1'b1;
            end
            default: begin
                n_spare++;
                return 1'b0;
            end
        endcase
    endfunction

    // Offer one beat after a random gap, wait for acceptance, then predict
    task automatic send_beat(input logic [S_TUSER_W-1:0] cmd, input t_coord px,
                             input t_coord py, input logic [TW-1:0] tf,
                             input bit typed, input t_curve_pt fixed);
        t_curve_pt pred;
        bit        gives;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({tf, py, px});
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        gives = predict_curve(cmd, px, py, tf, pred);
        if (gives)
            curve_due.push_back(typed ? fixed : pred);
    endtask

    function automatic t_coord pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0: return CURVE_TOP;
                1: return CURVE_BOTTOM;
                2: return t_coord'(0);
                default: return t_coord'(-1);
            endcase
        end
        if (r < 40)
            return t_coord'(int'($urandom_range(0, 8191)) - 4096);
        return t_coord'($urandom);
    endfunction

    function automatic logic [TW-1:0] pick_t();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return TW'($urandom_range(0, 65536));
        if (r < 80)
            return $urandom_range(0, 1) ? T_ONE : TW'(0);
        return TW'($urandom_range(0, 131071));
    endfunction

    // Check each curve point on the output against the oldest prediction
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && m_tvalid && m_tready) begin
            n_results++;
            if (curve_due.size() == 0) begin
                $display("%0t: unexpected curve point x=%h y=%h", $time,
                         m_tdata[CW-1:0], m_tdata[2*CW-1:CW]);
                errors++;
            end else begin
                due_pt = curve_due.pop_front();
                if (m_tdata[CW-1:0] !== due_pt.cx) begin
                    $display("%0t: curve_x expected %h actual %h", $time,
                             due_pt.cx, m_tdata[CW-1:0]);
                    errors++;
                end
                if (m_tdata[2*CW-1:CW] !== due_pt.cy) begin
                    $display("%0t: curve_y expected %h actual %h", $time,
                             due_pt.cy, m_tdata[2*CW-1:CW]);
                    errors++;
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("catmull_rom_segment_evaluator_core_tb failed");
            $finish;
        end
    end

    initial begin
        t_plan_row            plan [PLAN_LEN];
        t_plan_row            row;
        logic [S_TUSER_W-1:0] cmd;
        int                   r;
        int                   ph;
        int                   counted;
        int                   i;

        // Directed rows: reset state, extreme fills, clear, four-point curve, overshoot
        plan = '{
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h00000, 1'b1, '{24'sd0, 24'sd0}},
            '{CMD_EVAL,  24'sd0, 24'sd0, T_ONE,     1'b1, '{24'sd0, 24'sd0}},
            '{CMD_ADD,   CURVE_TOP, CURVE_BOTTOM, 17'h00000, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h08000, 1'b1, '{CURVE_TOP, CURVE_BOTTOM}},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h1FFFF, 1'b1, '{CURVE_TOP, CURVE_BOTTOM}},
            '{CMD_CLEAR, 24'sd0, 24'sd0, 17'h00000, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h04000, 1'b1, '{CURVE_TOP, CURVE_BOTTOM}},
            '{CMD_ADD,   CURVE_BOTTOM, CURVE_TOP, 17'h00000, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h0FFFF, 1'b1, '{CURVE_BOTTOM, CURVE_TOP}},
            '{CMD_SPARE, 24'sh5A5A5A, -24'sh123456, 17'h1ABCD, 1'b0, '0},
            '{CMD_CLEAR, 24'sd0, 24'sd0, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   -24'sh001000, 24'sh000200, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   24'sh000100, -24'sh000300, 17'h00000, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h08000, 1'b0, '0},
            '{CMD_ADD,   24'sh002280, 24'sh000455, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   -24'sh000777, 24'sh007000, 17'h00000, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h00000, 1'b1,
              '{24'sh000100, -24'sh000300}},
            '{CMD_EVAL,  24'sd0, 24'sd0, T_ONE, 1'b1, '{24'sh002280, 24'sh000455}},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h1FFFF, 1'b1, '{24'sh002280, 24'sh000455}},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h00001, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h0FFFF, 1'b0, '0},
            '{CMD_CLEAR, 24'sd0, 24'sd0, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   CURVE_BOTTOM, CURVE_TOP, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   CURVE_TOP, CURVE_BOTTOM, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   CURVE_TOP, CURVE_BOTTOM, 17'h00000, 1'b0, '0},
            '{CMD_ADD,   CURVE_BOTTOM, CURVE_TOP, 17'h00000, 1'b0, '0},
            '{CMD_EVAL,  24'sd0, 24'sd0, 17'h08000, 1'b0, '0}
        };

        for (i = 0; i < 2; i++) begin
            win[i]  = '{default: 0};
            coef[i] = '{default: 0};
        end
        held        = 0;
        n_add       = 0;
        n_eval      = 0;
        n_clear     = 0;
        n_spare     = 0;
        n_clamp     = 0;
        gap_pct     = 0;
        stall_pct   = 0;

        // Hold reset with every input at a known value
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_CLEAR;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan without idling
        for (i = 0; i < PLAN_LEN; i++) begin
            row = plan[i];
            send_beat(row.cmd, row.px, row.py, row.tf, row.typed, row.fixed);
        end

        // Random beats in four phases of differing gap and stall rates; mostly adds and evaluations
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 86; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 86; end
                default: begin gap_pct = 19; stall_pct = 19; end
            endcase
            counted = 0;
            while (counted < 100) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    cmd = CMD_CLEAR;
                else if (r < 7)
                    cmd = CMD_SPARE;
                else if (r < 37)
                    cmd = CMD_ADD;
                else
                    cmd = CMD_EVAL;
                send_beat(cmd, pick_coord(), pick_coord(), pick_t(), 1'b0, '0);
                if (cmd != CMD_SPARE)
                    counted++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding curve points, then watch for strays
        stall_pct = 0;
        while (curve_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d adds, %0d evaluations, %0d clears, %0d unused commands",
                 n_add, n_eval, n_clear, n_spare);
        $display("%0d curve points checked, %0d of the predicted coordinates clamped",
                 n_results, n_clamp);
        if (errors == 0)
            $display("catmull_rom_segment_evaluator_core_tb passed");
        else
            $display("catmull_rom_segment_evaluator_core_tb failed");
        $finish;
    end

endmodule
